// File: hw/rtl/msp_pkg.sv
// ----------------------------------------------------------------------------
// Multi-stack shared pool package
// Field widths, action and status codes, defaults and the control command
// type shared by the controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package msp_pkg;

    localparam int DEF_POOL_ENTRIES = 64;
    localparam int DEF_MAX_STACKS   = 8;

    localparam int ACTION_W   = 2;
    localparam int STACK_ID_W = 3;
    localparam int WORD_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int SLOT_W     = 6;
    localparam int COUNT_W    = 7;
    localparam int CFG_W      = 4;

    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    localparam logic [ACTION_W-1:0] ACT_PUSH = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_POP  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_PEEK = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_SIZE = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_STACK = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic accept;
        logic execute;
    } t_cmd;

endpackage

// File: hw/rtl/msp_ctrl.sv
// ----------------------------------------------------------------------------
// Multi-stack shared pool controller
// Two-state sequencer: takes a request, then executes it once the output
// register can take the result. Owns the handshakes on both channels.
// ----------------------------------------------------------------------------
module msp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    output logic          o_valid,
    input  logic          i_stall,
    output msp_pkg::t_cmd o_cmd
);
    import msp_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state;
    logic n_state;
    logic r_out_valid;
    logic n_out_valid;
    logic out_free;
    logic accept;
    logic execute;

    assign accept   = i_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_stall;
    assign execute  = (r_state == S_EXEC) && out_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (accept) n_state = S_EXEC;
            S_EXEC: if (execute) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
        n_out_valid = execute || (r_out_valid && i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_cmd.accept   = accept;
    assign o_cmd.execute  = execute;

    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_EXEC))
        else $error("accepted request did not enter execution");

    a_exec_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        execute |=> o_valid)
        else $error("executed request produced no result");

    a_exec_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) && !execute |=> (r_state == S_EXEC) && o_valid)
        else $error("request left execution without a free output register");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        execute |-> !(r_out_valid && i_stall))
        else $error("result overwritten while the receiver stalls");

endmodule

// File: hw/rtl/msp_datapath.sv
// ----------------------------------------------------------------------------
// Multi-stack shared pool datapath
// Pool memories, free chain, stack tops and counts, and the result register.
// Memories are read at the accept edge and written at the execute edge.
// ----------------------------------------------------------------------------
module msp_datapath #(
    parameter int POOL_ENTRIES = msp_pkg::DEF_POOL_ENTRIES,
    parameter int MAX_STACKS   = msp_pkg::DEF_MAX_STACKS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  msp_pkg::t_cmd                        i_cmd,
    input  logic                                 i_cfg_we,
    input  logic [msp_pkg::CFG_W-1:0]            i_cfg_data,
    input  logic [msp_pkg::ACTION_W-1:0]         i_action,
    input  logic [msp_pkg::STACK_ID_W-1:0]       i_stack_id,
    input  logic signed [msp_pkg::WORD_W-1:0]    i_push_value,
    output logic [msp_pkg::STATUS_W-1:0]         o_status,
    output logic signed [msp_pkg::WORD_W-1:0]    o_result_value,
    output logic [msp_pkg::SLOT_W-1:0]           o_top_slot,
    output logic [msp_pkg::COUNT_W-1:0]          o_stack_count
);
    import msp_pkg::*;

    localparam int LW          = $clog2(POOL_ENTRIES + 1);
    localparam int AW          = $clog2(POOL_ENTRIES);
    localparam int ID_SPAN     = 1 << STACK_ID_W;
    localparam int STACK_SLOTS = (MAX_STACKS < ID_SPAN) ? MAX_STACKS : ID_SPAN;
    localparam int IDX_W       = (STACK_SLOTS > 1) ? $clog2(STACK_SLOTS) : 1;
    localparam logic [LW-1:0] LINK_NULL = LW'(POOL_ENTRIES);

    logic [CFG_W-1:0]      r_cfg;
    logic [LW-1:0]         r_top [STACK_SLOTS];
    logic [LW-1:0]         r_size [STACK_SLOTS];
    logic [LW-1:0]         r_free_head;
    logic [LW-1:0]         r_fill_count;

    logic [WORD_W-1:0]     r_data_mem [POOL_ENTRIES];
    logic [LW-1:0]         r_link_mem [POOL_ENTRIES];
    logic [WORD_W-1:0]     r_data_rd;
    logic [LW-1:0]         r_link_rd;

    logic [ACTION_W-1:0]   r_action;
    logic [STACK_ID_W-1:0] r_sid;
    logic [WORD_W-1:0]     r_word;
    logic [LW-1:0]         r_cur_top;
    logic [LW-1:0]         r_cur_size;

    logic [STATUS_W-1:0]   r_status;
    logic [WORD_W-1:0]     r_value;
    logic [SLOT_W-1:0]     r_slot;
    logic [COUNT_W-1:0]    r_count;

    logic [IDX_W-1:0]      acc_idx;
    logic [IDX_W-1:0]      exe_idx;
    logic [LW-1:0]         acc_top;
    logic [AW-1:0]         data_ra;
    logic [AW-1:0]         link_ra;

    logic                  bad;
    logic                  full;
    logic                  empty;
    logic                  untouched;
    logic [LW-1:0]         push_link;

    logic [LW-1:0]         n_free_head;
    logic [LW-1:0]         n_fill_count;
    logic [LW-1:0]         n_top;
    logic [LW-1:0]         n_size;
    logic                  stack_we;
    logic                  data_we;
    logic                  link_we;
    logic [AW-1:0]         link_wa;
    logic [LW-1:0]         link_wd;
    logic [STATUS_W-1:0]   n_status;
    logic [WORD_W-1:0]     n_value;
    logic [SLOT_W-1:0]     n_slot;
    logic [COUNT_W-1:0]    n_count;

    // Stack numbers beyond the implemented stacks never index the arrays.
    assign acc_idx = (int'(i_stack_id) < STACK_SLOTS) ? i_stack_id[IDX_W-1:0] : '0;
    assign exe_idx = (int'(r_sid) < STACK_SLOTS) ? r_sid[IDX_W-1:0] : '0;
    assign acc_top = r_top[acc_idx];
    assign data_ra = acc_top[AW-1:0];
    assign link_ra = (i_action == ACT_PUSH) ? r_free_head[AW-1:0] : acc_top[AW-1:0];

    // Slots at or above the fill count were never linked since reset, so their
    // link is not used; the free chain goes on to the next slot, then to null.
    assign bad       = ({1'b0, r_sid} >= r_cfg) || (int'(r_sid) >= MAX_STACKS);
    assign full      = (r_free_head >= LINK_NULL);
    assign empty     = (r_cur_top >= LINK_NULL);
    assign untouched = (r_free_head >= r_fill_count);
    assign push_link = untouched ? (r_free_head + LW'(1)) : r_link_rd;

    always_comb begin
        n_free_head  = r_free_head;
        n_fill_count = r_fill_count;
        n_top        = r_cur_top;
        n_size       = r_cur_size;
        stack_we     = 1'b0;
        data_we      = 1'b0;
        link_we      = 1'b0;
        link_wa      = r_cur_top[AW-1:0];
        link_wd      = r_free_head;
        n_status     = ST_OK;
        n_value      = '0;
        n_slot       = '0;
        n_count      = '0;
        if (bad) begin
            n_status = ST_BAD_STACK;
        end else begin
            unique case (r_action)
                ACT_PUSH: begin
                    if (full) begin
                        n_status = ST_FULL;
                        n_count  = COUNT_W'(r_cur_size);
                    end else begin
                        data_we     = 1'b1;
                        link_we     = 1'b1;
                        link_wa     = r_free_head[AW-1:0];
                        link_wd     = r_cur_top;
                        stack_we    = 1'b1;
                        n_top       = r_free_head;
                        n_free_head = push_link;
                        if (untouched) begin
                            n_fill_count = r_fill_count + LW'(1);
                        end
                        if (r_cur_size != LINK_NULL) begin
                            n_size = r_cur_size + LW'(1);
                        end
                        n_value = r_word;
                        n_slot  = SLOT_W'(r_free_head);
                        n_count = COUNT_W'(n_size);
                    end
                end
                ACT_POP: begin
                    if (empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        link_we     = 1'b1;
                        stack_we    = 1'b1;
                        n_top       = r_link_rd;
                        n_free_head = r_cur_top;
                        if (r_cur_size != '0) begin
                            n_size = r_cur_size - LW'(1);
                        end
                        n_value = r_data_rd;
                        n_count = COUNT_W'(n_size);
                    end
                end
                ACT_PEEK: begin
                    if (empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_value = r_data_rd;
                        n_slot  = SLOT_W'(r_cur_top);
                        n_count = COUNT_W'(r_cur_size);
                    end
                end
                ACT_SIZE: begin
                    n_count = COUNT_W'(r_cur_size);
                end
                default: n_status = ST_OK;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg        <= CFG_RESET;
            r_free_head  <= '0;
            r_fill_count <= '0;
            for (int i = 0; i < STACK_SLOTS; i++) begin
                r_top[i]  <= LINK_NULL;
                r_size[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
            if (i_cmd.execute) begin
                r_free_head  <= n_free_head;
                r_fill_count <= n_fill_count;
                if (stack_we) begin
                    r_top[exe_idx]  <= n_top;
                    r_size[exe_idx] <= n_size;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_action   <= i_action;
            r_sid      <= i_stack_id;
            r_word     <= i_push_value;
            r_cur_top  <= acc_top;
            r_cur_size <= r_size[acc_idx];
            r_data_rd  <= r_data_mem[data_ra];
            r_link_rd  <= r_link_mem[link_ra];
        end
        if (i_cmd.execute) begin
            if (data_we) begin
                r_data_mem[r_free_head[AW-1:0]] <= r_word;
            end
            if (link_we) begin
                r_link_mem[link_wa] <= link_wd;
            end
            r_status <= n_status;
            r_value  <= n_value;
            r_slot   <= n_slot;
            r_count  <= n_count;
        end
    end

    assign o_status       = r_status;
    assign o_result_value = r_value;
    assign o_top_slot     = r_slot;
    assign o_stack_count  = r_count;

    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill_count <= LINK_NULL)
        else $error("fill count ran past the pool size");

    a_push_takes_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.execute && data_we |=> (r_free_head != $past(r_free_head)))
        else $error("push did not advance the free chain");

    a_pop_frees_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.execute && !bad && (r_action == ACT_POP) && !empty
        |=> (r_free_head == $past(r_cur_top)))
        else $error("popped slot not returned to the free chain head");

endmodule

// File: hw/rtl/multi_stack_shared_pool_top.sv
// ----------------------------------------------------------------------------
// Multi-stack shared pool
// Up to eight stacks share one pool of entries linked through a free chain.
//
// Requests arrive on i_valid/o_stall with i_action, i_stack_id and
// i_push_value; one result per request leaves on o_valid/i_stall with
// o_status, o_result_value, o_top_slot and o_stack_count. A transfer happens
// at a rising edge with valid high and stall low.
// At the accept edge a request reads the pool data and link memories; at the
// execute edge it writes them back and loads the result register, and the
// result is valid from then on. A new request is accepted only once the
// previous one has executed. When the receiver stalls, the result register
// holds; one more request is accepted and waits in execution until the
// register is free. Reset empties all stacks, chains the pool in slot order
// and sets the stack limit to eight. i_cfg_we writes the limit; the user must
// do so only while the block is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
module multi_stack_shared_pool_top #(
    parameter int POOL_ENTRIES = msp_pkg::DEF_POOL_ENTRIES,
    parameter int MAX_STACKS   = msp_pkg::DEF_MAX_STACKS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [msp_pkg::CFG_W-1:0]            i_cfg_data,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [msp_pkg::ACTION_W-1:0]         i_action,
    input  logic [msp_pkg::STACK_ID_W-1:0]       i_stack_id,
    input  logic signed [msp_pkg::WORD_W-1:0]    i_push_value,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [msp_pkg::STATUS_W-1:0]         o_status,
    output logic signed [msp_pkg::WORD_W-1:0]    o_result_value,
    output logic [msp_pkg::SLOT_W-1:0]           o_top_slot,
    output logic [msp_pkg::COUNT_W-1:0]          o_stack_count
);
    import msp_pkg::*;

    t_cmd cmd;

    msp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (cmd)
    );

    msp_datapath #(
        .POOL_ENTRIES (POOL_ENTRIES),
        .MAX_STACKS   (MAX_STACKS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_action       (i_action),
        .i_stack_id     (i_stack_id),
        .i_push_value   (i_push_value),
        .o_status       (o_status),
        .o_result_value (o_result_value),
        .o_top_slot     (o_top_slot),
        .o_stack_count  (o_stack_count)
    );

endmodule

// File: verif/tb_multi_stack_shared_pool_top.sv
// ----------------------------------------------------------------------------
// Multi-stack shared pool testbench
// Drives push, pop, peek and size requests into the shared pool through the
// request channel, and checks every result against directed values or a
// behavioral model of the stacks and the free chain kept in this file. A short
// directed table covers empty stacks, extreme words, slot reuse after a pop and
// the stack limit; random phases then fill the pool until it is full, drain it
// and mix requests under several stack limits, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_multi_stack_shared_pool_top;

    import msp_pkg::*;

    localparam int POOL_SIZE      = DEF_POOL_ENTRIES;
    localparam int STACK_SLOTS    = DEF_MAX_STACKS;
    localparam int NULL_LINK      = POOL_SIZE;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PRINT_LIMIT    = 100;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [WORD_W-1:0]   value;
        logic [SLOT_W-1:0]   slot;
        logic [COUNT_W-1:0]  count;
    } t_outcome;

    typedef enum logic [1:0] {
        ROW_REQ_TYPED,
        ROW_REQ_PRED,
        ROW_CFG
    } t_row_kind;

    typedef struct {
        t_row_kind             kind;
        logic [ACTION_W-1:0]   act;
        logic [STACK_ID_W-1:0] sid;
        logic [WORD_W-1:0]     word;
        t_outcome              outcome;
    } t_step_row;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_we = 1'b0;
    logic [CFG_W-1:0]             cfg_data = '0;
    logic                         req_valid = 1'b0;
    logic                         req_stall;
    logic [ACTION_W-1:0]          req_action = ACT_SIZE;
    logic [STACK_ID_W-1:0]        req_stack_id = '0;
    logic signed [WORD_W-1:0]     req_value = '0;
    logic                         rsp_valid;
    logic                         rsp_stall = 1'b0;
    logic [STATUS_W-1:0]          rsp_status;
    logic signed [WORD_W-1:0]     rsp_value;
    logic [SLOT_W-1:0]            rsp_slot;
    logic [COUNT_W-1:0]           rsp_count;

    logic [WORD_W-1:0]            pool_word [POOL_SIZE];
    logic [6:0]                   pool_next [POOL_SIZE];
    logic [6:0]                   head_of [STACK_SLOTS];
    logic [6:0]                   depth_of [STACK_SLOTS];
    logic [6:0]                   free_slot;
    logic [CFG_W-1:0]             stack_limit;

    t_outcome                     expected_q [$];
    t_step_row                    directed_rows [$];
    int                           mismatch_count = 0;
    int                           result_seq = 0;
    int                           idle_cycles = 0;
    int                           tx_idle_pct = 30;
    int                           rx_idle_pct = 30;
    int                           rx_stall_left = 0;

    multi_stack_shared_pool_top i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_data     (cfg_data),
        .i_valid        (req_valid),
        .o_stall        (req_stall),
        .i_action       (req_action),
        .i_stack_id     (req_stack_id),
        .i_push_value   (req_value),
        .o_valid        (rsp_valid),
        .i_stall        (rsp_stall),
        .o_status       (rsp_status),
        .o_result_value (rsp_value),
        .o_top_slot     (rsp_slot),
        .o_stack_count  (rsp_count)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        if ($urandom_range(99) < 88) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(12, 40);
    endfunction

    function automatic t_outcome predict_request(input logic [ACTION_W-1:0] act,
                                                 input logic [STACK_ID_W-1:0] sid,
                                                 input logic [WORD_W-1:0] word);
        t_outcome   res;
        logic [6:0] slot;
        res = '0;
        if (sid >= stack_limit || sid >= STACK_SLOTS) begin
            res.status = ST_BAD_STACK;
            return res;
        end
        res.status = ST_OK;
        case (act)
            ACT_PUSH: begin
                if (free_slot >= POOL_SIZE) begin
                    res.status = ST_FULL;
                    res.count  = depth_of[sid];
                end else begin
                    slot            = free_slot;
                    pool_word[slot] = word;
                    free_slot       = pool_next[slot];
                    pool_next[slot] = head_of[sid];
                    head_of[sid]    = slot;
                    if (depth_of[sid] < POOL_SIZE) begin
                        depth_of[sid] = depth_of[sid] + 7'd1;
                    end
                    res.value = word;
                    res.slot  = slot[SLOT_W-1:0];
                    res.count = depth_of[sid];
                end
            end
            ACT_POP: begin
                slot = head_of[sid];
                if (slot >= POOL_SIZE) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.value       = pool_word[slot];
                    head_of[sid]    = pool_next[slot];
                    pool_next[slot] = free_slot;
                    free_slot       = slot;
                    if (depth_of[sid] > 0) begin
                        depth_of[sid] = depth_of[sid] - 7'd1;
                    end
                    res.count = depth_of[sid];
                end
            end
            ACT_PEEK: begin
                slot = head_of[sid];
                if (slot >= POOL_SIZE) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.value = pool_word[slot];
                    res.slot  = slot[SLOT_W-1:0];
                    res.count = depth_of[sid];
                end
            end
            default: begin
                res.count = depth_of[sid];
            end
        endcase
        return res;
    endfunction

    function automatic void row_check(input logic [ACTION_W-1:0] act,
                                      input logic [STACK_ID_W-1:0] sid,
                                      input logic [WORD_W-1:0] word,
                                      input logic [STATUS_W-1:0] st,
                                      input logic [WORD_W-1:0] val,
                                      input logic [SLOT_W-1:0] slot,
                                      input logic [COUNT_W-1:0] cnt);
        t_step_row r;
        r.kind    = ROW_REQ_TYPED;
        r.act     = act;
        r.sid     = sid;
        r.word    = word;
        r.outcome = {st, val, slot, cnt};
        directed_rows.push_back(r);
    endfunction

    function automatic void row_pred(input logic [ACTION_W-1:0] act,
                                     input logic [STACK_ID_W-1:0] sid,
                                     input logic [WORD_W-1:0] word);
        t_step_row r;
        r.kind    = ROW_REQ_PRED;
        r.act     = act;
        r.sid     = sid;
        r.word    = word;
        r.outcome = '0;
        directed_rows.push_back(r);
    endfunction

    function automatic void row_cfg(input logic [CFG_W-1:0] limit);
        t_step_row r;
        r.kind    = ROW_CFG;
        r.act     = ACT_SIZE;
        r.sid     = '0;
        r.word    = {{(WORD_W-CFG_W){1'b0}}, limit};
        r.outcome = '0;
        directed_rows.push_back(r);
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT) begin
            $display("ERROR at %0t: %s", $realtime, msg);
        end
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [WORD_W-1:0] got,
                               input logic [WORD_W-1:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d %s got %0h want %0h",
                                      result_seq, name, got, want));
        end
    endtask

    task automatic check_result();
        t_outcome want;
        if (expected_q.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                      result_seq));
        end else begin
            want = expected_q.pop_front();
            check_field("status", WORD_W'(rsp_status), WORD_W'(want.status));
            check_field("value", rsp_value, want.value);
            check_field("top_slot", WORD_W'(rsp_slot), WORD_W'(want.slot));
            check_field("stack_count", WORD_W'(rsp_count), WORD_W'(want.count));
        end
        result_seq++;
    endtask

    task automatic send_request(input logic [ACTION_W-1:0] act,
                                input logic [STACK_ID_W-1:0] sid,
                                input logic [WORD_W-1:0] word,
                                input bit use_typed, input t_outcome typed_outcome);
        int       gap;
        t_outcome predicted;
        gap = ($urandom_range(99) < tx_idle_pct) ? pick_gap() : 0;
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid    <= 1'b1;
        req_action   <= act;
        req_stack_id <= sid;
        req_value    <= word;
        do @(posedge clk); while (req_stall !== 1'b0);
        predicted = predict_request(act, sid, word);
        expected_q.push_back(use_typed ? typed_outcome : predicted);
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [CFG_W-1:0] limit);
        wait_drained();
        cfg_we   <= 1'b1;
        cfg_data <= limit;
        @(posedge clk);
        cfg_we      <= 1'b0;
        stack_limit = limit;
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] limit, input int items,
                             input int push_pct, input int tx_pct, input int rx_pct);
        logic [ACTION_W-1:0]   act;
        logic [STACK_ID_W-1:0] sid;
        logic [WORD_W-1:0]     word;
        int                    roll;
        write_limit(limit);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        repeat (items) begin
            roll = $urandom_range(99);
            if (roll < push_pct) begin
                act = ACT_PUSH;
            end else begin
                roll = $urandom_range(99);
                act  = (roll < 60) ? ACT_POP : (roll < 85) ? ACT_PEEK : ACT_SIZE;
            end
            if (limit != 0 && $urandom_range(99) < 85) begin
                sid = STACK_ID_W'($urandom_range((limit > STACK_SLOTS) ?
                                                 STACK_SLOTS - 1 : limit - 1));
            end else begin
                sid = STACK_ID_W'($urandom_range(STACK_SLOTS - 1));
            end
            roll = $urandom_range(99);
            if (roll < 3) begin
                word = '0;
            end else if (roll < 6) begin
                word = '1;
            end else if (roll < 8) begin
                word = 32'h7FFF_FFFF;
            end else if (roll < 10) begin
                word = 32'h8000_0000;
            end else begin
                word = $urandom;
            end
            send_request(act, sid, word, 1'b0, '0);
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
            check_result();
        end
        if (rx_stall_left > 0) begin
            rx_stall_left--;
            rsp_stall <= 1'b1;
        end else if ($urandom_range(99) < rx_idle_pct) begin
            rx_stall_left = pick_gap() - 1;
            rsp_stall     <= 1'b1;
        end else begin
            rsp_stall <= 1'b0;
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (req_valid && req_stall === 1'b0)
                || (rsp_valid === 1'b1 && !rsp_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_word[i] = '0;
            pool_next[i] = 7'(i + 1);
        end
        for (int s = 0; s < STACK_SLOTS; s++) begin
            head_of[s]  = 7'(NULL_LINK);
            depth_of[s] = '0;
        end
        free_slot   = '0;
        stack_limit = CFG_RESET;

        row_check(ACT_SIZE, 3'd0, 32'h0, ST_OK, 32'h0, 6'd0, 7'd0);
        row_check(ACT_POP, 3'd0, 32'h0, ST_EMPTY, 32'h0, 6'd0, 7'd0);
        row_check(ACT_PEEK, 3'd7, 32'h0, ST_EMPTY, 32'h0, 6'd0, 7'd0);
        row_check(ACT_PUSH, 3'd0, 32'h7FFF_FFFF, ST_OK, 32'h7FFF_FFFF, 6'd0, 7'd1);
        row_check(ACT_PUSH, 3'd7, 32'h8000_0000, ST_OK, 32'h8000_0000, 6'd1, 7'd1);
        row_check(ACT_PEEK, 3'd0, 32'h0, ST_OK, 32'h7FFF_FFFF, 6'd0, 7'd1);
        row_check(ACT_PUSH, 3'd0, 32'hFFFF_FFFF, ST_OK, 32'hFFFF_FFFF, 6'd2, 7'd2);
        row_check(ACT_POP, 3'd0, 32'h0, ST_OK, 32'hFFFF_FFFF, 6'd0, 7'd1);
        row_pred(ACT_PUSH, 3'd3, 32'h0);
        row_pred(ACT_PEEK, 3'd3, 32'h0);
        row_pred(ACT_SIZE, 3'd7, 32'h0);
        row_pred(ACT_POP, 3'd7, 32'h0);
        row_check(ACT_SIZE, 3'd5, 32'h0, ST_OK, 32'h0, 6'd0, 7'd0);
        row_cfg(4'd0);
        row_check(ACT_PUSH, 3'd0, 32'h5A5A_5A5A, ST_BAD_STACK, 32'h0, 6'd0, 7'd0);
        row_check(ACT_SIZE, 3'd7, 32'h0, ST_BAD_STACK, 32'h0, 6'd0, 7'd0);
        row_cfg(4'd15);
        row_pred(ACT_PUSH, 3'd7, 32'hA5A5_A5A5);
        row_pred(ACT_POP, 3'd7, 32'h0);
        row_cfg(4'd1);
        row_check(ACT_PEEK, 3'd1, 32'h0, ST_BAD_STACK, 32'h0, 6'd0, 7'd0);
        row_pred(ACT_PEEK, 3'd0, 32'h0);
        row_check(ACT_POP, 3'd3, 32'h0, ST_BAD_STACK, 32'h0, 6'd0, 7'd0);
        row_cfg(4'd8);
        row_pred(ACT_POP, 3'd3, 32'h0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i]) begin
            case (directed_rows[i].kind)
                ROW_CFG: begin
                    write_limit(directed_rows[i].word[CFG_W-1:0]);
                end
                ROW_REQ_TYPED: begin
                    send_request(directed_rows[i].act, directed_rows[i].sid,
                                 directed_rows[i].word, 1'b1, directed_rows[i].outcome);
                end
                default: begin
                    send_request(directed_rows[i].act, directed_rows[i].sid,
                                 directed_rows[i].word, 1'b0, '0);
                end
            endcase
        end

        run_phase(4'd8, 170, 75, 30, 30);
        run_phase(4'd8, 100, 15, 20, 40);
        run_phase(4'd3, 80, 45, 0, 0);
        run_phase(4'd1, 60, 50, 20, 60);
        run_phase(4'd15, 80, 60, 40, 20);
        run_phase(4'd0, 20, 40, 20, 20);
        run_phase(4'd8, 60, 50, 25, 25);

        wait_drained();
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
